@@ src/echo_delay_mixer_top_macros.svh @@
// Assertion macros for the echo delay mixer; they compile away under synthesis.
`ifndef ECHO_DELAY_MIXER_TOP_MACROS_SVH
`define ECHO_DELAY_MIXER_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define EDM_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("echo_delay_mixer: same-cycle check failed");
`define EDM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("echo_delay_mixer: next-cycle check failed");
`else
`define EDM_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define EDM_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

@@ src/edm_pkg.sv @@
// Shared types and constants of the echo delay mixer.
package edm_pkg;

  localparam int unsigned DELAY_REG_W = 15;
  localparam int unsigned GAIN_W      = 16;
  localparam int unsigned CFG_DATA_W  = 16;

  localparam logic [DELAY_REG_W-1:0] DELAY_RESET = 15'd10000;
  localparam logic [GAIN_W-1:0]      GAIN_RESET  = 16'd52429;

  localparam logic CFG_DELAY = 1'b0;
  localparam logic CFG_GAIN  = 1'b1;

  localparam logic FUNC_SAMPLE = 1'b0;
  localparam logic FUNC_DRAIN  = 1'b1;

  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Per-transaction classification made by the front end.
  typedef struct packed {
    logic func;
    logic have_echo;
    logic last;
  } ctrl_t;

endpackage

@@ src/edm_fifo.sv @@
// Short queue that decouples the front end from the back end.
module edm_fifo #(
  parameter int unsigned W = 35
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        push,
  input  logic [W-1:0]                push_data,
  input  logic                        pop,
  output logic [W-1:0]                pop_data,
  output logic [edm_pkg::QCNT_W-1:0]  count
);

  localparam int unsigned PW = $clog2(edm_pkg::QUEUE_DEPTH);

  logic [W-1:0]               mem_r [edm_pkg::QUEUE_DEPTH];
  logic [PW-1:0]              wr_ptr_r, rd_ptr_r;
  logic [edm_pkg::QCNT_W-1:0] count_r;

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + PW'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + PW'(1);
      end
      if (push && !pop) begin
        count_r <= count_r + edm_pkg::QCNT_W'(1);
      end else if (pop && !push) begin
        count_r <= count_r - edm_pkg::QCNT_W'(1);
      end
    end
  end

  assign pop_data = mem_r[rd_ptr_r];
  assign count    = count_r;

endmodule

@@ src/edm_front.sv @@
// Front end: accepts transactions, keeps the clip counters and owns the delay store.
module edm_front #(
  parameter int unsigned DELAY_DEPTH = 16384,
  parameter int unsigned SAMPLE_BITS = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            in_func,
  input  logic signed [SAMPLE_BITS-1:0]   in_sample_in,
  input  logic [edm_pkg::DELAY_REG_W-1:0] delay_samples,
  input  logic [edm_pkg::QCNT_W-1:0]      q_count,
  output logic                            push,
  output edm_pkg::ctrl_t                  push_ctrl,
  output logic [SAMPLE_BITS-1:0]          push_sample,
  output logic [SAMPLE_BITS-1:0]          push_delayed
);

  localparam int unsigned AW = $clog2(DELAY_DEPTH);
  localparam int unsigned DW = $clog2(DELAY_DEPTH + 1);
  localparam int unsigned CW = (DW > edm_pkg::DELAY_REG_W) ? DW : edm_pkg::DELAY_REG_W;

  logic [SAMPLE_BITS-1:0] store_mem [DELAY_DEPTH];

  logic [AW-1:0] wi_r, wi_nxt;
  logic [DW-1:0] clip_r, clip_nxt;
  logic [DW-1:0] drain_r, drain_nxt;

  logic                   s1_valid_r;
  edm_pkg::ctrl_t         s1_ctrl_r;
  logic [SAMPLE_BITS-1:0] s1_sample_r;
  logic [SAMPLE_BITS-1:0] s1_rdata_r;

  logic                       accept;
  logic [CW-1:0]              delay_ext;
  logic [DW-1:0]              d_eff;
  logic [DW:0]                wi_ext;
  logic [DW:0]                ri_ext;
  logic [AW-1:0]              ri;
  logic [DW-1:0]              drain_inc;
  logic                       have_echo;
  logic                       last;
  logic [SAMPLE_BITS-1:0]     wdata;
  logic [edm_pkg::QCNT_W:0]   occupancy;

  assign occupancy = {1'b0, q_count} + {{edm_pkg::QCNT_W{1'b0}}, s1_valid_r};
  assign in_ready  = occupancy < (edm_pkg::QCNT_W + 1)'(edm_pkg::QUEUE_DEPTH);
  assign accept    = in_valid && in_ready;

  always_comb begin
    delay_ext = CW'(delay_samples);
    if (delay_ext == '0) begin
      d_eff = DW'(1);
    end else if (delay_ext > CW'(DELAY_DEPTH)) begin
      d_eff = DW'(DELAY_DEPTH);
    end else begin
      d_eff = DW'(delay_ext);
    end

    wi_ext = (DW + 1)'(wi_r);
    if (wi_ext >= {1'b0, d_eff}) begin
      ri_ext = wi_ext - {1'b0, d_eff};
    end else begin
      ri_ext = wi_ext + (DW + 1)'(DELAY_DEPTH) - {1'b0, d_eff};
    end
    ri = ri_ext[AW-1:0];

    have_echo = clip_r >= d_eff;
    drain_inc = drain_r + DW'(1);
    last      = (in_func == edm_pkg::FUNC_DRAIN) && (drain_inc >= d_eff);
    wdata     = (in_func == edm_pkg::FUNC_SAMPLE) ? in_sample_in : '0;

    wi_nxt    = wi_r;
    clip_nxt  = clip_r;
    drain_nxt = drain_r;
    if (accept) begin
      if (last) begin
        wi_nxt    = '0;
        clip_nxt  = '0;
        drain_nxt = '0;
      end else begin
        wi_nxt    = (wi_r == AW'(DELAY_DEPTH - 1)) ? '0 : wi_r + AW'(1);
        clip_nxt  = (clip_r < d_eff) ? clip_r + DW'(1) : d_eff;
        drain_nxt = (in_func == edm_pkg::FUNC_DRAIN) ? drain_inc : '0;
      end
    end
  end

  // Read-before-write store: the read sees the old entry when both addresses match.
  always_ff @(posedge clk) begin
    if (accept) begin
      store_mem[wi_r] <= wdata;
      s1_rdata_r      <= store_mem[ri];
      s1_sample_r     <= in_sample_in;
      s1_ctrl_r       <= '{func: in_func, have_echo: have_echo, last: last};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wi_r       <= '0;
      clip_r     <= '0;
      drain_r    <= '0;
      s1_valid_r <= 1'b0;
    end else begin
      wi_r       <= wi_nxt;
      clip_r     <= clip_nxt;
      drain_r    <= drain_nxt;
      s1_valid_r <= accept;
    end
  end

  assign push         = s1_valid_r;
  assign push_ctrl    = s1_ctrl_r;
  assign push_sample  = s1_sample_r;
  assign push_delayed = s1_rdata_r;

endmodule

@@ src/edm_back.sv @@
// Back end: echo multiply, mix and output register.
module edm_back #(
  parameter int unsigned SAMPLE_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          q_nonempty,
  output logic                          pop,
  input  edm_pkg::ctrl_t                pop_ctrl,
  input  logic [SAMPLE_BITS-1:0]        pop_sample,
  input  logic [SAMPLE_BITS-1:0]        pop_delayed,
  input  logic [edm_pkg::GAIN_W-1:0]    echo_gain,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [SAMPLE_BITS-1:0] out_sample_out,
  output logic                          out_tail_last
);

  localparam int unsigned PW = SAMPLE_BITS + edm_pkg::GAIN_W + 1;
  localparam int unsigned SW = PW + 1;

  logic                   m_valid_r;
  edm_pkg::ctrl_t         m_ctrl_r;
  logic signed [SAMPLE_BITS-1:0] m_sample_r;
  logic signed [PW-1:0]   m_prod_r;

  logic                          o_valid_r;
  logic signed [SAMPLE_BITS-1:0] o_sample_r;
  logic                          o_last_r;

  logic                          o_en, m_en;
  logic signed [SAMPLE_BITS-1:0] delayed_eff;
  logic signed [edm_pkg::GAIN_W:0] gain_s;
  logic signed [SW-1:0]          mix_sum;
  logic signed [SAMPLE_BITS-1:0] result;

  assign o_en = !o_valid_r || out_ready;
  assign m_en = !m_valid_r || o_en;
  assign pop  = q_nonempty && m_en;

  assign delayed_eff = pop_ctrl.have_echo ? signed'(pop_delayed) : '0;
  assign gain_s      = signed'({1'b0, echo_gain});

  always_comb begin
    mix_sum = SW'(signed'({m_sample_r, {edm_pkg::GAIN_W{1'b0}}})) + SW'(m_prod_r);
    if (m_ctrl_r.func == edm_pkg::FUNC_DRAIN) begin
      result = m_prod_r[SAMPLE_BITS-1+edm_pkg::GAIN_W:edm_pkg::GAIN_W];
    end else if (m_ctrl_r.have_echo) begin
      result = mix_sum[SAMPLE_BITS+edm_pkg::GAIN_W:edm_pkg::GAIN_W+1];
    end else begin
      result = m_sample_r;
    end
  end

  always_ff @(posedge clk) begin
    if (m_en && pop) begin
      m_ctrl_r   <= pop_ctrl;
      m_sample_r <= signed'(pop_sample);
      m_prod_r   <= PW'(gain_s) * PW'(delayed_eff);
    end
    if (o_en && m_valid_r) begin
      o_sample_r <= result;
      o_last_r   <= m_ctrl_r.last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_valid_r <= 1'b0;
      o_valid_r <= 1'b0;
    end else begin
      if (m_en) begin
        m_valid_r <= pop;
      end
      if (o_en) begin
        o_valid_r <= m_valid_r;
      end
    end
  end

  assign out_valid      = o_valid_r;
  assign out_sample_out = o_sample_r;
  assign out_tail_last  = o_last_r;

endmodule

@@ src/echo_delay_mixer_top.sv @@
// A result passes the front-end stage register, the queue, the multiply register and
// the output register. Throughput: one transaction per cycle while out_ready holds,
// set by the single read-before-write port of the delay store and one multiplier stage in the back end.
// Reset (synchronous, active low) clears counters, queue and valid flags and
// loads the register defaults; the delay store is not cleared and needs no sweep.
`include "echo_delay_mixer_top_macros.svh"
module echo_delay_mixer_top #(
  parameter int unsigned DELAY_DEPTH = 16384,
  parameter int unsigned SAMPLE_BITS = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           in_func,
  input  logic signed [SAMPLE_BITS-1:0]  in_sample_in,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic signed [SAMPLE_BITS-1:0]  out_sample_out,
  output logic                           out_tail_last,
  input  logic                           cfg_we,
  input  logic                           cfg_index,
  input  logic [edm_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  // Each queue entry carries the classification, the clip sample and the
  // sample read from the delay store for that transaction.
  localparam int unsigned QW = $bits(edm_pkg::ctrl_t) + 2 * SAMPLE_BITS;

  logic [edm_pkg::DELAY_REG_W-1:0] delay_r;
  logic [edm_pkg::GAIN_W-1:0]      gain_r;

  logic                       q_push, q_pop;
  edm_pkg::ctrl_t             push_ctrl, pop_ctrl;
  logic [SAMPLE_BITS-1:0]     push_sample, push_delayed;
  logic [SAMPLE_BITS-1:0]     pop_sample, pop_delayed;
  logic [QW-1:0]              q_wdata, q_rdata;
  logic [edm_pkg::QCNT_W-1:0] q_count;

  // Configuration registers. The user must make writes only while no transaction is
  // in flight; the block itself does not enforce this. Both ends read them directly.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      delay_r <= edm_pkg::DELAY_RESET;
      gain_r  <= edm_pkg::GAIN_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        edm_pkg::CFG_DELAY: delay_r <= cfg_wdata[edm_pkg::DELAY_REG_W-1:0];
        edm_pkg::CFG_GAIN:  gain_r  <= cfg_wdata[edm_pkg::GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  // The front end tracks clip position, drain count and the circular write
  // index, and reads the delayed sample in the same cycle it stores the new one.
  edm_front #(
    .DELAY_DEPTH (DELAY_DEPTH),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_func       (in_func),
    .in_sample_in  (in_sample_in),
    .delay_samples (delay_r),
    .q_count       (q_count),
    .push          (q_push),
    .push_ctrl     (push_ctrl),
    .push_sample   (push_sample),
    .push_delayed  (push_delayed)
  );

  assign q_wdata = {push_ctrl, push_sample, push_delayed};

  // The front end only accepts a transaction when a queue slot is reserved
  // for it, so the queue absorbs any stall from the output side.
  edm_fifo #(
    .W (QW)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_wdata),
    .pop       (q_pop),
    .pop_data  (q_rdata),
    .count     (q_count)
  );

  assign {pop_ctrl, pop_sample, pop_delayed} = q_rdata;

  // The back end scales the delayed sample by the gain, mixes it with the
  // clip sample (or passes the scaled echo on drain ticks) and holds the result.
  edm_back #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_nonempty     (q_count != '0),
    .pop            (q_pop),
    .pop_ctrl       (pop_ctrl),
    .pop_sample     (pop_sample),
    .pop_delayed    (pop_delayed),
    .echo_gain      (gain_r),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_sample_out (out_sample_out),
    .out_tail_last  (out_tail_last)
  );

  // The queue never takes an entry while full and never gives one while empty.
  `EDM_ASSERT_NOW(a_no_overflow, clk, rst_n, q_push && !q_pop, q_count < edm_pkg::QCNT_W'(edm_pkg::QUEUE_DEPTH))
  `EDM_ASSERT_NOW(a_no_underflow, clk, rst_n, q_pop, q_count != '0)
  // A clip sample never ends a clip.
  `EDM_ASSERT_NOW(a_sample_not_last, clk, rst_n, q_push && (push_ctrl.func == edm_pkg::FUNC_SAMPLE), !push_ctrl.last)
  // An accepted transaction always reaches the queue on the next cycle.
  `EDM_ASSERT_NEXT(a_accept_pushes, clk, rst_n, in_valid && in_ready, q_push)

endmodule

@@ dv/tb.sv @@
// Self-checking testbench for the echo delay mixer: directed clips, deep delay, random clips.
`timescale 1ns / 1ps
module tb;

  localparam int unsigned DEPTH = 16384;
  localparam int unsigned SBITS = 16;

  // One expected transaction on the result channel.
  typedef struct {
    logic signed [SBITS-1:0] mixed;
    logic                    tail;
  } mix_result_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_valid = 1'b0;
  logic                   in_ready;
  logic                   in_func = edm_pkg::FUNC_SAMPLE;
  logic signed [SBITS-1:0] in_sample_in = '0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  logic signed [SBITS-1:0] out_sample_out;
  logic                   out_tail_last;
  logic                   cfg_we = 1'b0;
  logic                   cfg_index = edm_pkg::CFG_DELAY;
  logic [edm_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

  // Our own copy of the block's state and registers, advanced once per accepted
  // input transaction.
  logic signed [SBITS-1:0] echo_store [DEPTH];
  int unsigned             wr_idx = 0;
  int unsigned             clip_pos = 0;
  int unsigned             drain_cnt = 0;
  logic [edm_pkg::DELAY_REG_W-1:0] delay_reg = edm_pkg::DELAY_RESET;
  logic [edm_pkg::GAIN_W-1:0]      gain_reg = edm_pkg::GAIN_RESET;

  mix_result_t mix_expected[$];
  int          errors = 0;
  int          items_sent = 0;
  int          in_idle_pct = 0;
  int          out_stall_pct = 0;

  echo_delay_mixer_top #(
    .DELAY_DEPTH(DEPTH),
    .SAMPLE_BITS(SBITS)
  ) dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_func       (in_func),
    .in_sample_in  (in_sample_in),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_sample_out(out_sample_out),
    .out_tail_last (out_tail_last),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata)
  );

  always #10 clk = ~clk;

  initial begin
    foreach (echo_store[i]) echo_store[i] = '0;
  end

  // A delay of zero behaves as one, and anything beyond the store depth is
  // clamped to the depth.
  function automatic int unsigned eff_delay();
    if (delay_reg == 0) return 1;
    if (delay_reg > DEPTH) return DEPTH;
    return delay_reg;
  endfunction

  // Works out the result of one input transaction and advances the mirrored state.
  function automatic mix_result_t mix_predict(logic f, logic signed [SBITS-1:0] x);
    int unsigned             d;
    int unsigned             ri;
    logic                    have_echo;
    logic signed [SBITS-1:0] delayed;
    longint                  product;
    longint                  acc;
    mix_result_t             r;
    d         = eff_delay();
    ri        = (wr_idx + DEPTH - d) % DEPTH;
    // Before the clip has run for a full delay there is no echo yet.
    have_echo = (clip_pos >= d);
    delayed   = have_echo ? echo_store[ri] : '0;
    product   = longint'(gain_reg) * longint'(delayed);
    r.tail    = 1'b0;
    if (f == edm_pkg::FUNC_SAMPLE) begin
      acc = longint'(x) * 65536 + product;
      r.mixed = have_echo ? SBITS'(acc >>> 17) : x;
      echo_store[wr_idx] = x;
      drain_cnt = 0;
    end else begin
      r.mixed = SBITS'(product >>> 16);
      echo_store[wr_idx] = '0;
      drain_cnt++;
      if (drain_cnt >= d) r.tail = 1'b1;
    end
    if (r.tail) begin
      wr_idx    = 0;
      clip_pos  = 0;
      drain_cnt = 0;
    end else begin
      wr_idx   = (wr_idx + 1) % DEPTH;
      clip_pos = (clip_pos < d) ? clip_pos + 1 : d;
    end
    return r;
  endfunction

  task automatic report_mismatch(input string what);
    errors++;
    $display("MISMATCH at %0t ns: %s", $time, what);
  endtask

  // Every accepted input transaction queues its expected result. Values are
  // sampled at the edge, before any nonblocking update of that edge lands.
  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) mix_expected.push_back(mix_predict(in_func, in_sample_in));
  end

  // Each accepted result is compared with the oldest expectation.
  always @(posedge clk) begin : check_results
    mix_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (mix_expected.size() == 0) begin
        report_mismatch($sformatf("unexpected result %0d tail %0b", out_sample_out,
                                  out_tail_last));
      end else begin
        want = mix_expected.pop_front();
        if (out_sample_out !== want.mixed)
          report_mismatch($sformatf("sample_out %0d, expected %0d", out_sample_out, want.mixed));
        if (out_tail_last !== want.tail)
          report_mismatch($sformatf("tail_last %0b, expected %0b", out_tail_last, want.tail));
      end
    end
  end

  // The receiver stalls at random with the probability of the current phase.
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= out_stall_pct);
  end

  // Sends one transaction. It is called right after a rising edge and returns on
  // the edge that accepts the transaction, so valid is never dropped and raised
  // again within one step.
  task automatic send_mix_item(input logic f, input logic signed [SBITS-1:0] s);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_func      <= f;
    in_sample_in <= s;
    do @(posedge clk); while (!(in_valid && in_ready));
    items_sent++;
  endtask

  // Stops sending and waits until every expected result has come out, then lets
  // the pipeline settle.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (mix_expected.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Register write; only called while the block is idle, so the mirror can be
  // updated right away.
  task automatic write_reg(input logic idx, input logic [edm_pkg::CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == edm_pkg::CFG_DELAY) delay_reg = data[edm_pkg::DELAY_REG_W-1:0];
    else gain_reg = data;
    @(posedge clk);
  endtask

  function automatic logic signed [SBITS-1:0] pick_sample();
    case ($urandom_range(7))
      0: return 16'sh8000;
      1: return 16'sh7fff;
      2: return '0;
      3: return -16'sd1;
      default: return SBITS'($urandom);
    endcase
  endfunction

  function automatic logic [edm_pkg::CFG_DATA_W-1:0] pick_gain();
    case ($urandom_range(5))
      0: return '0;
      1: return '1;
      2: return edm_pkg::GAIN_RESET;
      default: return edm_pkg::CFG_DATA_W'($urandom);
    endcase
  endfunction

  // Small delays keep clips and drains short in the random part.
  function automatic logic [edm_pkg::CFG_DATA_W-1:0] pick_delay();
    case ($urandom_range(15))
      0: return '0;
      1: return 16'd1;
      default: return edm_pkg::CFG_DATA_W'($urandom_range(2, 24));
    endcase
  endfunction

  // Default registers: clip samples pass through until the delay is reached.
  // The delay is then lowered below the clip length (with the unused top data
  // bit set) so the reset gain is used for echoes, and a drain ends the clip.
  task automatic test_default_settings();
    send_mix_item(edm_pkg::FUNC_SAMPLE, 16'sh7fff);
    send_mix_item(edm_pkg::FUNC_SAMPLE, 16'sh8000);
    send_mix_item(edm_pkg::FUNC_SAMPLE, 16'sd1234);
    wait_idle();
    write_reg(edm_pkg::CFG_DELAY, 16'h8002);
    send_mix_item(edm_pkg::FUNC_SAMPLE, -16'sd1);
    send_mix_item(edm_pkg::FUNC_SAMPLE, 16'sd20000);
    send_mix_item(edm_pkg::FUNC_DRAIN, 16'sh5a5a);
    send_mix_item(edm_pkg::FUNC_DRAIN, 16'sh0000);
  endtask

  // Drain ticks with no clip before them give zero, and the final one is still
  // flagged. A delay of zero acts as one.
  task automatic test_drain_without_clip();
    wait_idle();
    write_reg(edm_pkg::CFG_DELAY, 16'd0);
    send_mix_item(edm_pkg::FUNC_DRAIN, 16'sh7fff);
    wait_idle();
    write_reg(edm_pkg::CFG_DELAY, 16'd3);
    repeat (3) send_mix_item(edm_pkg::FUNC_DRAIN, 16'sh8000);
  endtask

  // Full-scale samples against the largest and smallest gains.
  task automatic test_extremes();
    wait_idle();
    write_reg(edm_pkg::CFG_DELAY, 16'd1);
    write_reg(edm_pkg::CFG_GAIN, 16'hffff);
    send_mix_item(edm_pkg::FUNC_SAMPLE, 16'sh7fff);
    send_mix_item(edm_pkg::FUNC_SAMPLE, 16'sh7fff);
    send_mix_item(edm_pkg::FUNC_SAMPLE, 16'sh8000);
    send_mix_item(edm_pkg::FUNC_SAMPLE, -16'sd1);
    send_mix_item(edm_pkg::FUNC_DRAIN, 16'sh0000);
    wait_idle();
    write_reg(edm_pkg::CFG_GAIN, 16'h0000);
    send_mix_item(edm_pkg::FUNC_SAMPLE, 16'sh8000);
    send_mix_item(edm_pkg::FUNC_SAMPLE, 16'sh7fff);
    send_mix_item(edm_pkg::FUNC_DRAIN, 16'sh0000);
  endtask

  // A clip sample arriving during a drain restarts the drain count.
  task automatic test_clip_during_drain();
    wait_idle();
    write_reg(edm_pkg::CFG_DELAY, 16'd3);
    write_reg(edm_pkg::CFG_GAIN, 16'd40000);
    repeat (4) send_mix_item(edm_pkg::FUNC_SAMPLE, pick_sample());
    send_mix_item(edm_pkg::FUNC_DRAIN, 16'sh0000);
    send_mix_item(edm_pkg::FUNC_SAMPLE, 16'sh8000);
    repeat (3) send_mix_item(edm_pkg::FUNC_DRAIN, 16'sh0000);
  endtask

  // An oversized delay clamps to the store depth; lowering it mid-drain ends the
  // drain on the next tick.
  task automatic test_delay_lowered_during_drain();
    wait_idle();
    write_reg(edm_pkg::CFG_DELAY, 16'h7fff);
    repeat (4) send_mix_item(edm_pkg::FUNC_SAMPLE, pick_sample());
    repeat (2) send_mix_item(edm_pkg::FUNC_DRAIN, 16'sh0000);
    wait_idle();
    write_reg(edm_pkg::CFG_DELAY, 16'd2);
    send_mix_item(edm_pkg::FUNC_DRAIN, 16'sh0000);
  endtask

  // The deepest delay: a short clip passes through unchanged, drain ticks give
  // zero, and a lowered delay then ends the drain.
  task automatic test_full_depth();
    wait_idle();
    in_idle_pct   = 0;
    out_stall_pct = 0;
    write_reg(edm_pkg::CFG_DELAY, 16'd16384);
    write_reg(edm_pkg::CFG_GAIN, pick_gain());
    repeat (20) send_mix_item(edm_pkg::FUNC_SAMPLE, pick_sample());
    repeat (3) send_mix_item(edm_pkg::FUNC_DRAIN, 16'sh0000);
    wait_idle();
    write_reg(edm_pkg::CFG_DELAY, 16'd1);
    send_mix_item(edm_pkg::FUNC_DRAIN, 16'sh0000);
  endtask

  // Random clips for one idling phase. Most traffic is whole clips followed by a
  // full drain; some clips are cut by an early clip sample, and some traffic is
  // plain noise.
  task automatic test_random_clips(input int idle_in, input int stall_out, input int quota);
    int          first;
    int unsigned d;
    int          pick;
    wait_idle();
    in_idle_pct   = idle_in;
    out_stall_pct = stall_out;
    first = items_sent;
    while (items_sent - first < quota) begin
      if (items_sent == first || $urandom_range(9) == 0) begin
        wait_idle();
        write_reg(edm_pkg::CFG_DELAY, pick_delay());
        write_reg(edm_pkg::CFG_GAIN, pick_gain());
      end
      d    = eff_delay();
      pick = $urandom_range(9);
      if (pick < 7) begin
        repeat ($urandom_range(0, 3 * d + 2))
          send_mix_item(edm_pkg::FUNC_SAMPLE, pick_sample());
        repeat (d) send_mix_item(edm_pkg::FUNC_DRAIN, SBITS'($urandom));
      end else if (pick == 7) begin
        repeat ($urandom_range(d, 2 * d)) send_mix_item(edm_pkg::FUNC_SAMPLE, pick_sample());
        repeat ($urandom_range(1, d)) send_mix_item(edm_pkg::FUNC_DRAIN, SBITS'($urandom));
        repeat ($urandom_range(1, d)) send_mix_item(edm_pkg::FUNC_SAMPLE, pick_sample());
        repeat (d) send_mix_item(edm_pkg::FUNC_DRAIN, SBITS'($urandom));
      end else begin
        repeat ($urandom_range(1, 8)) send_mix_item(1'($urandom_range(1)), SBITS'($urandom));
      end
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_default_settings();
    test_drain_without_clip();
    test_extremes();
    test_clip_during_drain();
    test_delay_lowered_during_drain();
    test_full_depth();
    test_random_clips(0, 0, 255);
    test_random_clips(53, 0, 255);
    test_random_clips(0, 53, 255);
    test_random_clips(37, 37, 255);

    // Let the last results come out; anything still pending is a failure.
    in_valid <= 1'b0;
    for (int n = 0; n < 20000 && mix_expected.size() != 0; n++) @(posedge clk);
    while (mix_expected.size() != 0) begin
      void'(mix_expected.pop_front());
      report_mismatch("expected result never arrived");
    end
    repeat (8) @(posedge clk);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run of about 1200 transactions.
  initial begin
    #10000000;
    $display("Some tests failed");
    $finish;
  end

endmodule
